@@ sv/soft_viterbi_decoder_k5_unit_macros.svh @@
// Assertion macros shared by the soft-decision Viterbi decoder.
// Depends on nothing; included by files that carry assertions.
`ifndef SOFT_VITERBI_DECODER_K5_UNIT_MACROS_SVH
`define SOFT_VITERBI_DECODER_K5_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/svd_pkg.sv @@
// Package for the soft-decision Viterbi decoder: constants and a trellis function.
// Depends on nothing.
`default_nettype none
package svd_pkg;
    localparam int NumStates = 16;
    localparam int DefTracebackDepth = 32;
    localparam int DefSoftBits = 8;
    localparam int DefMetricBits = 24;
    localparam logic [4:0] PolyA = 5'h17;
    localparam logic [4:0] PolyB = 5'h19;

    // Coded pair for predecessor state s and input bit b: {first, second}.
    function automatic logic [1:0] code_pair(input logic [3:0] s, input logic b);
        logic [4:0] w;
        begin
            w = {b, s};
            code_pair = {^(w & PolyA), ^(w & PolyB)};
        end
    endfunction
endpackage
`default_nettype wire

@@ sv/soft_viterbi_decoder_k5_unit.sv @@
// Top level of the soft-decision Viterbi decoder (K=5, rate 1/2, 16 states).
// Depends on svd_pkg and soft_viterbi_decoder_k5_unit_macros.svh.
`default_nettype none
`include "soft_viterbi_decoder_k5_unit_macros.svh"
// One symbol (a pair of signed soft samples, +2^(SOFT_BITS-2) meaning +1.0) is
// taken per transfer while in_stall is low; the block then works alone on it.
// A single shared add-compare-select unit walks the 16 next states one per
// cycle, a minimum/best-state pass over the 16 states follows, and then a
// renormalize pass writes the metrics back. Once the survivor ring is full,
// a ring read setup step, a serial traceback of one ring entry per cycle
// (TRACEBACK_DEPTH entries) and an output load step follow. These passes run
// in turn since there is a single ACS unit and a single ring read port.
// The decoded bit sits in an output register, and the next symbol is accepted
// while it waits to be taken; only if the previous bit is still held when the
// next traceback ends does the block wait for the output side.
// There is no clearing pass: the ring is only read once it has been filled.
module soft_viterbi_decoder_k5_unit #(
    parameter int TRACEBACK_DEPTH = svd_pkg::DefTracebackDepth,
    parameter int SOFT_BITS       = svd_pkg::DefSoftBits,
    parameter int METRIC_BITS     = svd_pkg::DefMetricBits
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire signed [SOFT_BITS-1:0] soft_first,
    input  wire signed [SOFT_BITS-1:0] soft_second,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic                       decoded_bit
);
    localparam int PtrBits = $clog2(TRACEBACK_DEPTH);
    localparam int CntBits = $clog2(TRACEBACK_DEPTH + 1);
    localparam int BmBits  = 2 * SOFT_BITS + 1;
    localparam logic [METRIC_BITS-1:0] MetricMax = '1;
    localparam logic [PtrBits-1:0] LastIdx = PtrBits'(TRACEBACK_DEPTH - 1);
    localparam logic [CntBits-1:0] FullCnt = CntBits'(TRACEBACK_DEPTH);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StAcs  = 3'd1;
    localparam logic [2:0] StMin  = 3'd2;
    localparam logic [2:0] StNorm = 3'd3;
    localparam logic [2:0] StRead = 3'd4;
    localparam logic [2:0] StTb   = 3'd5;
    localparam logic [2:0] StOut  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg;
    logic [PtrBits-1:0] tb_cnt_reg;
    logic signed [SOFT_BITS-1:0] x0_reg, x1_reg;
    logic [METRIC_BITS-1:0] pm_reg [svd_pkg::NumStates];
    logic [METRIC_BITS-1:0] nm_reg [svd_pkg::NumStates];
    logic [15:0] reached_reg, nr_reg, dec_reg;
    logic [PtrBits-1:0] wp_reg, idx_reg;
    logic [CntBits-1:0] fill_reg;
    logic [METRIC_BITS-1:0] min_reg;
    logic [3:0] best_reg, st_reg;
    logic any_reg, bit_reg;
    logic out_valid_reg, out_bit_reg;
    logic [15:0] ring [TRACEBACK_DEPTH];
    logic [15:0] ring_rd_reg;

    // Shared ACS unit for next state cnt_reg.
    logic [3:0] pe, po;
    logic b;
    logic [1:0] ce, co;
    logic [BmBits-1:0] bm_e, bm_o;
    logic [METRIC_BITS:0] me_sum, mo_sum;
    logic [METRIC_BITS-1:0] me, mo;
    logic sel_odd, any_pred;

    function automatic logic [BmBits-1:0] bmetric(input logic [1:0] c,
                                                  input logic signed [SOFT_BITS-1:0] a0,
                                                  input logic signed [SOFT_BITS-1:0] a1);
        logic signed [SOFT_BITS+1:0] one, e0, e1;
        logic [2*SOFT_BITS+1:0] q0, q1;
        begin
            one = (SOFT_BITS+2)'(1) <<< (SOFT_BITS - 2);
            e0 = (c[1] ? one : -one) - (SOFT_BITS+2)'(a0);
            e1 = (c[0] ? one : -one) - (SOFT_BITS+2)'(a1);
            q0 = (2*SOFT_BITS+2)'(e0 * e0);
            q1 = (2*SOFT_BITS+2)'(e1 * e1);
            bmetric = BmBits'(q0 + q1);
        end
    endfunction

    always_comb
    begin
        b = cnt_reg[3];
        pe = {cnt_reg[2:0], 1'b0};
        po = {cnt_reg[2:0], 1'b1};
        ce = svd_pkg::code_pair(pe, b);
        co = svd_pkg::code_pair(po, b);
        bm_e = bmetric(ce, x0_reg, x1_reg);
        bm_o = bmetric(co, x0_reg, x1_reg);
        me_sum = {1'b0, pm_reg[pe]} + (METRIC_BITS+1)'(bm_e);
        mo_sum = {1'b0, pm_reg[po]} + (METRIC_BITS+1)'(bm_o);
        me = me_sum[METRIC_BITS] ? MetricMax : me_sum[METRIC_BITS-1:0];
        mo = mo_sum[METRIC_BITS] ? MetricMax : mo_sum[METRIC_BITS-1:0];
        sel_odd = reached_reg[po] && (!reached_reg[pe] || mo < me);
        any_pred = reached_reg[pe] || reached_reg[po];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            StIdle: if (in_valid) state_next = StAcs;
            StAcs:  if (cnt_reg == 4'd15) state_next = StMin;
            StMin:  if (cnt_reg == 4'd15) state_next = StNorm;
            StNorm:
                // The fill count steps at this same edge, so a count one short
                // of full already means the ring is full for this symbol.
                if (cnt_reg == 4'd15)
                    state_next = (fill_reg == FullCnt || fill_reg == FullCnt - 1'b1)
                                 ? StRead : StIdle;
            StRead: state_next = StTb;
            StTb:   if (tb_cnt_reg == LastIdx) state_next = StOut;
            StOut:  if (!out_valid_reg || !out_stall) state_next = StIdle;
            default: state_next = StIdle;
        endcase
    end

    assign in_stall    = (state_reg != StIdle);
    assign out_valid   = out_valid_reg;
    assign decoded_bit = out_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            cnt_reg       <= '0;
            tb_cnt_reg    <= '0;
            reached_reg   <= 16'h0001;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < svd_pkg::NumStates; i++) pm_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall && state_reg != StOut) out_valid_reg <= 1'b0;
            case (state_reg)
                StIdle:
                    if (in_valid)
                    begin
                        x0_reg  <= soft_first;
                        x1_reg  <= soft_second;
                        cnt_reg <= '0;
                        dec_reg <= '0;
                    end
                StAcs:
                begin
                    nr_reg[cnt_reg]  <= any_pred;
                    dec_reg[cnt_reg] <= sel_odd;
                    nm_reg[cnt_reg]  <= !any_pred ? '0 : (sel_odd ? mo : me);
                    cnt_reg <= cnt_reg + 4'd1;
                    any_reg <= 1'b0;
                    min_reg <= '0;
                    best_reg <= '0;
                end
                StMin:
                begin
                    if (nr_reg[cnt_reg] && (!any_reg || nm_reg[cnt_reg] < min_reg))
                    begin
                        min_reg  <= nm_reg[cnt_reg];
                        best_reg <= cnt_reg;
                        any_reg  <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                StNorm:
                begin
                    pm_reg[cnt_reg] <= nr_reg[cnt_reg] ? nm_reg[cnt_reg] - min_reg : '0;
                    reached_reg[cnt_reg] <= nr_reg[cnt_reg];
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        wp_reg  <= (wp_reg == LastIdx) ? '0 : wp_reg + 1'b1;
                        idx_reg <= wp_reg;
                        st_reg  <= best_reg;
                        if (fill_reg != FullCnt) fill_reg <= fill_reg + 1'b1;
                    end
                end
                StRead:
                begin
                    tb_cnt_reg <= '0;
                    idx_reg <= (idx_reg == '0) ? LastIdx : idx_reg - 1'b1;
                end
                StTb:
                begin
                    bit_reg <= st_reg[3];
                    st_reg  <= {st_reg[2:0], ring_rd_reg[st_reg]};
                    idx_reg <= (idx_reg == '0) ? LastIdx : idx_reg - 1'b1;
                    tb_cnt_reg <= tb_cnt_reg + 1'b1;
                end
                StOut:
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bit_reg   <= bit_reg;
                    end
                default: ;
            endcase
        end
    end

    // Survivor ring: written once per symbol at the start of the minimum pass,
    // read through a registered port whose address runs one step ahead of use.
    always_ff @(posedge clk)
    begin
        if (state_reg == StMin && cnt_reg == 4'd0) ring[wp_reg] <= dec_reg;
        ring_rd_reg <= ring[idx_reg];
    end

    `SVD_ASSERT_IMP(a_ready_idle, clk, rst_n, !in_stall, state_reg == StIdle,
        "input taken outside idle")
    `SVD_ASSERT_IMP(a_out_full, clk, rst_n, state_reg == StTb, fill_reg == FullCnt,
        "traceback before the ring is full")
    `SVD_ASSERT_NEXT(a_reach, clk, rst_n, state_reg == StNorm && cnt_reg == 4'd15,
        reached_reg != 16'h0000, "no reached state after renormalize")
endmodule
`default_nettype wire

@@ bench/tb_soft_viterbi_decoder_k5_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for soft_viterbi_decoder_k5_unit, the K=5 rate-1/2 decoder.
// Depends on svd_pkg and the decoder RTL; it has its own bit-exact trellis predictor.
module tb_soft_viterbi_decoder_k5_unit;

    localparam int DEPTH = svd_pkg::DefTracebackDepth;
    localparam int STATES = svd_pkg::NumStates;
    localparam longint unsigned METRIC_TOP = (64'd1 << svd_pkg::DefMetricBits) - 1;
    localparam int UNIT = 64;
    localparam int RANDOM_ITEMS = 1125;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_OFF_CYCLES = 400;

    // Traffic modes: who idles and how often.
    typedef enum int {SENDER_SPARSE, RECEIVER_SPARSE, FULL_RATE} traffic_mode_t;

    typedef struct packed {
        logic signed [7:0] first;
        logic signed [7:0] second;
    } soft_pair_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [7:0] soft_first;
    logic signed [7:0] soft_second;
    logic out_valid;
    logic out_stall;
    logic decoded_bit;

    soft_viterbi_decoder_k5_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .soft_first(soft_first),
        .soft_second(soft_second),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .decoded_bit(decoded_bit)
    );

    // The predictor keeps its own copy of the trellis state.
    longint unsigned metric_of[STATES];
    bit alive[STATES];
    logic [15:0] decision_ring[DEPTH];
    int ring_wr;
    int ring_fill;

    soft_pair_t symbol_queue[$];
    bit expected_bits[$];
    bit stimulus_done;
    bit in_took;
    int symbols_sent;
    int symbols_accepted;
    int bits_checked;
    int mismatch_count;
    int idle_cycles;
    bit hold_off_done;
    traffic_mode_t mode;

    // Clock with a 20 ns period.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s at decoded bit %0d: got %0d, expected %0d",
                 what, bits_checked, got, want);
        mismatch_count++;
    endtask

    // Squared-Euclidean distance between the received pair and the branch label
    // produced by leaving state s with information bit b.
    function automatic longint unsigned branch_cost(input int s, input int b,
                                                    input longint x0, input longint x1);
        logic [4:0] word;
        longint e0;
        longint e1;
        begin
            word = {b[0], s[3:0]};
            e0 = ((^(word & svd_pkg::PolyA)) ? UNIT : -UNIT) - x0;
            e1 = ((^(word & svd_pkg::PolyB)) ? UNIT : -UNIT) - x1;
            return longint'(e0 * e0 + e1 * e1);
        end
    endfunction

    // Advances the trellis by one symbol. When the survivor ring is full it
    // traces back from the best surviving state and queues the oldest bit.
    task automatic decode_symbol(input logic signed [7:0] a, input logic signed [7:0] b);
        longint unsigned next_metric[STATES];
        bit next_alive[STATES];
        logic [15:0] choices;
        longint unsigned cand_even;
        longint unsigned cand_odd;
        longint unsigned floor_metric;
        bit have_floor;
        bit found;
        int ns;
        int pe;
        int po;
        int best;
        int st;
        int info;
        int idx;
        int k;
        begin
            choices = '0;
            have_floor = 0;
            floor_metric = 0;
            for (ns = 0; ns < STATES; ns++)
            begin
                pe = (ns & 7) << 1;
                po = pe | 1;
                cand_even = 0;
                cand_odd = 0;
                next_metric[ns] = 0;
                next_alive[ns] = 0;
                if (alive[pe])
                begin
                    cand_even = metric_of[pe] + branch_cost(pe, ns >> 3, a, b);
                    if (cand_even > METRIC_TOP)
                        cand_even = METRIC_TOP;
                end
                if (alive[po])
                begin
                    cand_odd = metric_of[po] + branch_cost(po, ns >> 3, a, b);
                    if (cand_odd > METRIC_TOP)
                        cand_odd = METRIC_TOP;
                end
                // On a tie the even predecessor wins.
                if (alive[pe] && (!alive[po] || cand_even <= cand_odd))
                begin
                    next_metric[ns] = cand_even;
                    next_alive[ns] = 1;
                end
                else if (alive[po])
                begin
                    next_metric[ns] = cand_odd;
                    next_alive[ns] = 1;
                    choices[ns] = 1'b1;
                end
            end
            decision_ring[ring_wr] = choices;

            for (ns = 0; ns < STATES; ns++)
            begin
                if (next_alive[ns] && (!have_floor || next_metric[ns] < floor_metric))
                begin
                    floor_metric = next_metric[ns];
                    have_floor = 1;
                end
            end
            for (ns = 0; ns < STATES; ns++)
            begin
                alive[ns] = next_alive[ns];
                metric_of[ns] = next_alive[ns] ? next_metric[ns] - floor_metric : 0;
            end

            idx = ring_wr;
            ring_wr = (ring_wr + 1) % DEPTH;
            if (ring_fill < DEPTH)
                ring_fill++;
            if (ring_fill == DEPTH)
            begin
                // Lowest index wins among equally good states.
                best = 0;
                found = 0;
                for (ns = 0; ns < STATES; ns++)
                begin
                    if (alive[ns] && (!found || metric_of[ns] < metric_of[best]))
                    begin
                        best = ns;
                        found = 1;
                    end
                end
                st = best;
                info = 0;
                for (k = 0; k < DEPTH; k++)
                begin
                    info = st >> 3;
                    st = ((st & 7) << 1) | decision_ring[idx][st];
                    idx = (idx + DEPTH - 1) % DEPTH;
                end
                expected_bits.push_back(info[0]);
            end
        end
    endtask

    function automatic logic signed [7:0] clamp_soft(input int v);
        begin
            if (v > 127)
                return 8'sd127;
            if (v < -128)
                return -8'sd128;
            return v[7:0];
        end
    endfunction

    // Reset, then fill the symbol queue and wait for the run to drain.
    initial
    begin : stimulus
        int n;
        int enc_state;
        int info;
        int noise;
        int burst;
        logic [4:0] word;
        soft_pair_t p;

        rst_n = 1'b0;
        stimulus_done = 0;
        mismatch_count = 0;
        for (n = 0; n < STATES; n++)
        begin
            metric_of[n] = 0;
            alive[n] = (n == 0);
        end
        for (n = 0; n < DEPTH; n++)
            decision_ring[n] = '0;
        ring_wr = 0;
        ring_fill = 0;

        // Directed symbols: sample extremes, all four clean labels, erasures
        // that force ties everywhere, and mixed-sign corners.
        symbol_queue.push_back('{8'sd127, 8'sd127});
        symbol_queue.push_back('{-8'sd128, -8'sd128});
        symbol_queue.push_back('{8'sd127, -8'sd128});
        symbol_queue.push_back('{-8'sd128, 8'sd127});
        symbol_queue.push_back('{8'sd64, 8'sd64});
        symbol_queue.push_back('{-8'sd64, -8'sd64});
        symbol_queue.push_back('{8'sd64, -8'sd64});
        symbol_queue.push_back('{-8'sd64, 8'sd64});
        for (n = 0; n < 8; n++)
            symbol_queue.push_back('{8'sd0, 8'sd0});
        symbol_queue.push_back('{8'sd1, -8'sd1});
        symbol_queue.push_back('{-8'sd1, 8'sd1});
        symbol_queue.push_back('{8'sd0, 8'sd127});
        symbol_queue.push_back('{-8'sd128, 8'sd0});
        for (n = 0; n < 6; n++)
            symbol_queue.push_back('{8'sd127, -8'sd128});

        // Random part: mostly noisy codewords from a running encoder, with
        // bursts of raw noise.
        enc_state = 0;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 99) < 80)
            begin
                noise = $urandom_range(0, 70);
                repeat (burst)
                begin
                    info = $urandom_range(0, 1);
                    word = {info[0], enc_state[3:0]};
                    p.first = clamp_soft(((^(word & svd_pkg::PolyA)) ? UNIT : -UNIT)
                                         + int'($urandom_range(0, 2 * noise)) - noise);
                    p.second = clamp_soft(((^(word & svd_pkg::PolyB)) ? UNIT : -UNIT)
                                          + int'($urandom_range(0, 2 * noise)) - noise);
                    enc_state = (enc_state >> 1) | (info << 3);
                    symbol_queue.push_back(p);
                end
            end
            else
            begin
                repeat (burst)
                begin
                    p.first = 8'($urandom_range(0, 255));
                    p.second = 8'($urandom_range(0, 255));
                    symbol_queue.push_back(p);
                end
            end
            n += burst;
        end
        symbols_sent = 0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        wait (symbol_queue.size() == 0 && !in_valid);
        wait (expected_bits.size() == 0);
        stimulus_done = 1;
        repeat (200) @(posedge clk);

        $display("Decoded %0d bits from %0d symbols under three traffic mixes and a long",
                 bits_checked, symbols_accepted);
        $display("output hold-off; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0 && expected_bits.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // The traffic mix moves on as the run progresses.
    always_comb
    begin
        if (symbols_sent < 380)
            mode = SENDER_SPARSE;
        else if (symbols_sent < 760)
            mode = RECEIVER_SPARSE;
        else
            mode = FULL_RATE;
    end

    // Driver: a new symbol is offered only after the previous transfer, and a
    // stalled symbol is held untouched.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            soft_first <= '0;
            soft_second <= '0;
        end
        else if (!in_valid || in_took)
        begin
            if (symbol_queue.size() != 0 &&
                !(mode == SENDER_SPARSE && $urandom_range(0, 99) < 27) &&
                !(mode == RECEIVER_SPARSE && $urandom_range(0, 99) < 61))
            begin
                in_valid <= 1'b1;
                soft_first <= symbol_queue[0].first;
                soft_second <= symbol_queue[0].second;
                symbol_queue.pop_front();
                symbols_sent++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall. Once 900 symbols are sent (in the full-rate part) it holds
    // off for a long stretch, so the decoder fills up and pushes back on its input.
    always @(negedge clk or negedge rst_n)
    begin : receiver
        int hold_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_off_done = 0;
        end
        else
        begin
            if (!hold_off_done && symbols_sent >= 900)
            begin
                hold_off_done = 1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (mode == SENDER_SPARSE)
                out_stall <= ($urandom_range(0, 99) < 61);
            else if (mode == RECEIVER_SPARSE)
                out_stall <= ($urandom_range(0, 99) < 27);
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: check the output transfer first, since a symbol taken at this
    // edge cannot yet have produced its own bit.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
            bits_checked = 0;
            symbols_accepted = 0;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_bits.size() == 0)
                    report_mismatch("unexpected decoded_bit", decoded_bit, -1);
                else
                begin
                    if (decoded_bit !== expected_bits[0])
                        report_mismatch("decoded_bit", decoded_bit, expected_bits[0]);
                    expected_bits.pop_front();
                end
                bits_checked++;
            end
            if (in_valid && !in_stall)
            begin
                decode_symbol(soft_first, soft_second);
                symbols_accepted++;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || stimulus_done || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
